/* rtl/core/lcdseq_pkg.sv */
// ----------------------------------------------------------------------------
// lcdseq_pkg: shared definitions for the character LCD nibble write sequencer
// Codes, timing constants, the queued job format and the power-up tables.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

    localparam int CMD_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int NIB_W       = 4;
    localparam int HOLD_W      = 16;
    localparam int COUNT_W     = 6;
    localparam int PHASE_W     = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int INIT_IDX_W  = 3;

    // Input selector codes
    localparam logic [CMD_W-1:0] CMD_COMMAND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHAR    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POWERUP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_HOLD  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_DELAY = 1'b1;

    localparam logic [HOLD_W-1:0] ENABLE_HOLD_RESET  = 16'd25;
    localparam logic [HOLD_W-1:0] SETTLE_DELAY_RESET = 16'd1000;
    localparam logic [HOLD_W-1:0] IDLE_HOLD          = 16'd3000;
    localparam logic [HOLD_W-1:0] GAP_LONG           = 16'd30000;
    localparam logic [HOLD_W-1:0] GAP_SHORT          = 16'd800;
    localparam logic [HOLD_W-1:0] GAP_CLEAR          = 16'd10000;

    localparam logic [BYTE_W-1:0]  NEXT_LINE = 8'hC0;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    // Last phase index of each job shape
    localparam logic [PHASE_W-1:0] LAST_BYTE    = 5'd3;
    localparam logic [PHASE_W-1:0] LAST_BYTE_NL = 5'd7;
    localparam logic [PHASE_W-1:0] LAST_POWERUP = 5'd24;

    localparam int LINE_LENGTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic {
        JOB_BYTE    = 1'b0,
        JOB_POWERUP = 1'b1
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [BYTE_W-1:0] byte_value;
        logic              reg_select;
        logic              newline;     // follow the byte with a move to line two
    } job_t;

    typedef struct packed {
        logic [HOLD_W-1:0] enable_hold;
        logic [HOLD_W-1:0] settle_delay;
    } timing_t;

    typedef struct packed {
        logic [NIB_W-1:0]  data_nibble;
        logic              reg_select;
        logic              enable_line;
        logic [HOLD_W-1:0] hold_count;
        logic              last_phase;
    } phase_t;

    function automatic logic [BYTE_W-1:0] init_byte(input logic [INIT_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] val;
        begin
            case (idx)
                3'd0:    val = 8'h33;
                3'd1:    val = 8'h32;
                3'd2:    val = 8'h28;
                3'd3:    val = 8'h0C;
                3'd4:    val = 8'h06;
                3'd5:    val = 8'h01;
                default: val = 8'h00;
            endcase
            return val;
        end
    endfunction

    function automatic logic [HOLD_W-1:0] init_gap(input logic [INIT_IDX_W-1:0] idx);
        logic [HOLD_W-1:0] val;
        begin
            case (idx)
                3'd0, 3'd1, 3'd2: val = GAP_LONG;
                3'd3, 3'd4:       val = GAP_SHORT;
                3'd5:             val = GAP_CLEAR;
                default:          val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

/* rtl/core/lcdseq_front.sv */
// ----------------------------------------------------------------------------
// lcdseq_front: input classifier
// Turns each valid item into a job (unused selectors are dropped), tracks the per-string character count.
// ----------------------------------------------------------------------------
module lcdseq_front #(
    parameter int LINE_LENGTH = lcdseq_pkg::LINE_LENGTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lcdseq_pkg::CMD_W-1:0]     in_cmd,
    input  logic [lcdseq_pkg::BYTE_W-1:0]    in_byte_value,
    input  logic                             in_first,
    input  logic                             q_full,
    output logic                             q_push,
    output lcdseq_pkg::job_t                 q_job
);

    logic [lcdseq_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [lcdseq_pkg::COUNT_W-1:0] count_base;
    logic [lcdseq_pkg::COUNT_W-1:0] count_new;
    logic                           count_inc;
    logic                           accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        count_base = in_first ? '0 : count_reg;
        count_inc  = (count_base < lcdseq_pkg::COUNT_MAX);
        count_new  = count_inc ? count_base + 1'b1 : count_base;

        q_job            = '0;
        q_job.kind       = lcdseq_pkg::JOB_BYTE;
        q_job.byte_value = in_byte_value;
        q_push           = 1'b0;
        count_next       = count_reg;

        unique case (in_cmd)
            lcdseq_pkg::CMD_COMMAND: begin
                q_push = accept;
            end
            lcdseq_pkg::CMD_CHAR: begin
                q_push           = accept;
                q_job.reg_select = 1'b1;
                q_job.newline    = count_inc &&
                                   (count_new == lcdseq_pkg::COUNT_W'(LINE_LENGTH));
                if (accept) begin
                    count_next = count_new;
                end
            end
            lcdseq_pkg::CMD_POWERUP: begin
                q_push     = accept;
                q_job.kind = lcdseq_pkg::JOB_POWERUP;
            end
            default: begin
                // unused selector: drop the item
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/lcdseq_queue.sv */
// ----------------------------------------------------------------------------
// lcdseq_queue: job queue
// Short first-in first-out store between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module lcdseq_queue #(
    parameter int DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  lcdseq_pkg::job_t push_job,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output lcdseq_pkg::job_t head_job
);

    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0]  PTR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_TOP = COUNT_W'(DEPTH);

    lcdseq_pkg::job_t mem [DEPTH];

    logic [ADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == COUNT_TOP);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job popped from an empty queue");
`endif

endmodule

/* rtl/core/lcdseq_back.sv */
// ----------------------------------------------------------------------------
// lcdseq_back: pin phase sequencer
// Expands one job per run into pin phases, one phase per cycle unless the
// output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module lcdseq_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lcdseq_pkg::timing_t                timing,
    input  logic                               q_valid,
    input  lcdseq_pkg::job_t                   q_job,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output lcdseq_pkg::phase_t                 out_phase
);

    logic                             busy_reg, busy_next;
    lcdseq_pkg::job_t                 job_reg, job_next;
    logic [lcdseq_pkg::PHASE_W-1:0]   idx_reg, idx_next;
    logic                             out_valid_reg, out_valid_next;
    lcdseq_pkg::phase_t               out_reg, out_next;

    logic                             can_adv;
    logic [lcdseq_pkg::PHASE_W-1:0]   last_idx;
    logic [lcdseq_pkg::PHASE_W-1:0]   pos;
    logic [lcdseq_pkg::BYTE_W-1:0]    cur_byte;
    logic [lcdseq_pkg::HOLD_W-1:0]    cur_gap;
    logic                             cur_rs;
    logic [lcdseq_pkg::HOLD_W:0]      settle_sum;
    logic [lcdseq_pkg::HOLD_W-1:0]    settle_sat;
    lcdseq_pkg::phase_t               phase;

    assign can_adv   = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_phase = out_reg;

    // Phase generation for the current job and position
    always_comb begin
        if (job_reg.kind == lcdseq_pkg::JOB_POWERUP) begin
            last_idx = lcdseq_pkg::LAST_POWERUP;
            pos      = idx_reg - 1'b1;
            cur_byte = lcdseq_pkg::init_byte(pos[4:2]);
            cur_gap  = lcdseq_pkg::init_gap(pos[4:2]);
            cur_rs   = 1'b0;
        end else begin
            last_idx = job_reg.newline ? lcdseq_pkg::LAST_BYTE_NL : lcdseq_pkg::LAST_BYTE;
            pos      = idx_reg;
            cur_byte = pos[2] ? lcdseq_pkg::NEXT_LINE : job_reg.byte_value;
            cur_gap  = '0;
            cur_rs   = pos[2] ? 1'b0 : job_reg.reg_select;
        end

        settle_sum = {1'b0, timing.settle_delay} + {1'b0, cur_gap};
        settle_sat = settle_sum[lcdseq_pkg::HOLD_W] ? '1
                                                    : settle_sum[lcdseq_pkg::HOLD_W-1:0];

        phase.data_nibble = pos[1] ? cur_byte[3:0] : cur_byte[7:4];
        phase.reg_select  = cur_rs;
        phase.enable_line = !pos[0];
        if (!pos[0]) begin
            phase.hold_count = timing.enable_hold;
        end else if (pos[1]) begin
            phase.hold_count = settle_sat;
        end else begin
            phase.hold_count = '0;
        end
        phase.last_phase = (idx_reg == last_idx);

        // leading idle phase of the power-up run
        if (job_reg.kind == lcdseq_pkg::JOB_POWERUP && idx_reg == '0) begin
            phase.data_nibble = '0;
            phase.reg_select  = 1'b0;
            phase.enable_line = 1'b0;
            phase.hold_count  = lcdseq_pkg::IDLE_HOLD;
        end
    end

    always_comb begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;

        if (can_adv) begin
            out_valid_next = 1'b0;
        end

        if (busy_reg && can_adv) begin
            out_valid_next = 1'b1;
            out_next       = phase;
            if (phase.last_phase) begin
                // chain straight into the next job
                busy_next = q_valid;
                q_pop     = q_valid;
                job_next  = q_job;
                idx_next  = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end else if (!busy_reg && q_valid) begin
            busy_next = 1'b1;
            q_pop     = 1'b1;
            job_next  = q_job;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= last_idx))
        else $error("phase index ran past the end of its job");

    a_stall_holds_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready && busy_reg) |=> $stable(idx_reg))
        else $error("phase index moved while the output stage was stalled");

    a_last_is_enable_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.last_phase) |-> !out_reg.enable_line)
        else $error("final phase of an item with enable high");
`endif

endmodule

/* rtl/core/char_lcd_nibble_write_sequencer_top.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_top: 4-bit character LCD write sequencer
// Accepts command, character and power-up requests and emits pin phases.
// ----------------------------------------------------------------------------
// The first phase of an item accepted into an idle block passes the queue
// write, the job load and the output register in turn. Throughput: one
// phase per cycle while m_tready is high; a byte is 4 phases, a wrapping
// character 8, the power-up run 25. Jobs chain with no gap if one is queued.
// Reset (aresetn low, synchronous): queue empty, sequencer idle, character
// count zero, enable_hold 25 and settle_delay 1000.
module char_lcd_nibble_write_sequencer_top #(
    parameter int LINE_LENGTH = lcdseq_pkg::LINE_LENGTH_DEFAULT,
    parameter int QUEUE_DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] byte_value, [8] first_in_string, rest zero
    input  logic [1:0]  s_tuser,    // [1:0] cmd

    // result items, one per pin phase
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [3:0] data_nibble, [4] enable_line,
                                    // [20:5] hold_count, rest zero
    output logic [0:0]  m_tuser,    // [0] reg_select
    output logic        m_tlast,    // last_phase

    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [lcdseq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lcdseq_pkg::HOLD_W-1:0]        cfg_wdata
);

    lcdseq_pkg::timing_t timing_reg;
    lcdseq_pkg::job_t    push_job;
    lcdseq_pkg::job_t    head_job;
    lcdseq_pkg::phase_t  phase;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;

    // Configuration registers: write on enable, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.enable_hold  <= lcdseq_pkg::ENABLE_HOLD_RESET;
            timing_reg.settle_delay <= lcdseq_pkg::SETTLE_DELAY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lcdseq_pkg::REG_ENABLE_HOLD:  timing_reg.enable_hold  <= cfg_wdata;
                lcdseq_pkg::REG_SETTLE_DELAY: timing_reg.settle_delay <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Front: classify items, keep the per-string character count
    lcdseq_front #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_cmd        (s_tuser),
        .in_byte_value (s_tdata[7:0]),
        .in_first      (s_tdata[8]),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    // Queue: decouple acceptance from phase generation
    lcdseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    // Back: expand jobs into pin phases
    lcdseq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .timing    (timing_reg),
        .q_valid   (q_valid),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_phase (phase)
    );

    // Pack the phase onto the result channel
    assign m_tdata = {3'b000, phase.hold_count, phase.enable_line, phase.data_nibble};
    assign m_tuser = phase.reg_select;
    assign m_tlast = phase.last_phase;

endmodule

/* test/tb_char_lcd_nibble_write_sequencer_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_write_sequencer_top: pin phase checks for the LCD sequencer
// Drives command, character, power-up and ignored items with random gaps and stalls,
// keeps its own model of the timing registers and the per-string character
// count, and compares every emitted pin phase with the predicted one.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_write_sequencer_top;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 5;
    localparam int MAX_WAIT       = 8;
    // Quiet cycles after the last phase, covers the queue, job and output
    // registers plus an ignored item still in flight.
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LINE_LEN       = lcdseq_pkg::LINE_LENGTH_DEFAULT;
    localparam int RANDOM_ITEMS   = 280;
    localparam int ITEMS_PER_PASS = 40;

    // Selector value the block must ignore
    localparam logic [lcdseq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Power-up bytes and the extra gap after each, first entry in the top bits
    localparam logic [6*lcdseq_pkg::BYTE_W-1:0] POWERUP_BYTES = 48'h33_32_28_0C_06_01;
    localparam logic [6*lcdseq_pkg::HOLD_W-1:0] POWERUP_GAPS  =
        {lcdseq_pkg::GAP_LONG, lcdseq_pkg::GAP_LONG, lcdseq_pkg::GAP_LONG,
         lcdseq_pkg::GAP_SHORT, lcdseq_pkg::GAP_SHORT, lcdseq_pkg::GAP_CLEAR};

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [15:0]                        s_tdata;    // [7:0] byte_value, [8] first_in_string
    logic [1:0]                         s_tuser;    // [1:0] cmd
    logic                               m_tvalid;
    logic                               m_tready;
    logic [23:0]                        m_tdata;    // [3:0] data_nibble, [4] enable_line,
                                                    // [20:5] hold_count
    logic [0:0]                         m_tuser;    // [0] reg_select
    logic                               m_tlast;    // last_phase
    logic                               cfg_wr_en;
    logic [lcdseq_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lcdseq_pkg::HOLD_W-1:0]      cfg_wdata;

    // Model state: timing registers and the per-string character count
    logic [lcdseq_pkg::HOLD_W-1:0]  model_enable_hold;
    logic [lcdseq_pkg::HOLD_W-1:0]  model_settle_delay;
    logic [lcdseq_pkg::COUNT_W-1:0] model_char_count;

    lcdseq_pkg::phase_t pending_phases[$];
    int                 mismatch_count = 0;
    int                 idle_cycles = 0;
    bit                 gaps_on = 1'b1;

    char_lcd_nibble_write_sequencer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Pin phase prediction
    // ------------------------------------------------------------------------

    // Queue one pin state; hold counts clip at the 16-bit maximum.
    function automatic void push_phase(input logic [lcdseq_pkg::NIB_W-1:0] nib,
                                       input logic rs, input logic en,
                                       input int unsigned hold);
        lcdseq_pkg::phase_t ph;
        ph.data_nibble = nib;
        ph.reg_select  = rs;
        ph.enable_line = en;
        ph.hold_count  = (hold > 32'hFFFF) ? 16'hFFFF : hold[lcdseq_pkg::HOLD_W-1:0];
        ph.last_phase  = 1'b0;
        pending_phases.push_back(ph);
    endfunction

    // High nibble then low nibble, each as E high then E low.
    function automatic void push_byte(input logic [lcdseq_pkg::BYTE_W-1:0] b,
                                      input logic rs,
                                      input logic [lcdseq_pkg::HOLD_W-1:0] gap);
        push_phase(b[7:4], rs, 1'b1, {16'd0, model_enable_hold});
        push_phase(b[7:4], rs, 1'b0, 0);
        push_phase(b[3:0], rs, 1'b1, {16'd0, model_enable_hold});
        push_phase(b[3:0], rs, 1'b0, {16'd0, model_settle_delay} + {16'd0, gap});
    endfunction

    function automatic void predict_pin_phases(input logic [lcdseq_pkg::CMD_W-1:0] cmd,
                                               input logic [lcdseq_pkg::BYTE_W-1:0] bv,
                                               input logic first);
        int                 start;
        lcdseq_pkg::phase_t tail;
        start = pending_phases.size();
        case (cmd)
            lcdseq_pkg::CMD_COMMAND: begin
                push_byte(bv, 1'b0, '0);
            end
            lcdseq_pkg::CMD_CHAR: begin
                if (first) begin
                    model_char_count = '0;
                end
                push_byte(bv, 1'b1, '0);
                // count saturates, so a long string wraps only once
                if (model_char_count < lcdseq_pkg::COUNT_MAX) begin
                    model_char_count = model_char_count + 1'b1;
                    if (model_char_count == LINE_LEN) begin
                        push_byte(lcdseq_pkg::NEXT_LINE, 1'b0, '0);
                    end
                end
            end
            lcdseq_pkg::CMD_POWERUP: begin
                push_phase('0, 1'b0, 1'b0, {16'd0, lcdseq_pkg::IDLE_HOLD});
                for (int i = 0; i < 6; i++) begin
                    push_byte(POWERUP_BYTES[6*lcdseq_pkg::BYTE_W-1-lcdseq_pkg::BYTE_W*i
                                            -: lcdseq_pkg::BYTE_W], 1'b0,
                              POWERUP_GAPS[6*lcdseq_pkg::HOLD_W-1-lcdseq_pkg::HOLD_W*i
                                           -: lcdseq_pkg::HOLD_W]);
                end
            end
            default: ;
        endcase
        // flag the final phase of this item
        if (pending_phases.size() > start) begin
            tail = pending_phases.pop_back();
            tail.last_phase = 1'b1;
            pending_phases.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Send one item; called at a rising edge, returns at the edge it is taken.
    task automatic send_item(input logic [lcdseq_pkg::CMD_W-1:0] cmd,
                             input logic [lcdseq_pkg::BYTE_W-1:0] bv,
                             input logic first);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, first, bv};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        predict_pin_phases(cmd, bv, first);
    endtask

    // A string: the first character restarts the count.
    task automatic send_string(input int len);
        for (int i = 0; i < len; i++) begin
            send_item(lcdseq_pkg::CMD_CHAR, $urandom_range(0, 255), i == 0);
        end
    endtask

    // Drop valid, drain every expected phase, then let the pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_phases.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lcdseq_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lcdseq_pkg::HOLD_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        if (idx == lcdseq_pkg::REG_ENABLE_HOLD) begin
            model_enable_hold = value;
        end else begin
            model_settle_delay = value;
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_timing(input logic [lcdseq_pkg::HOLD_W-1:0] enable_hold,
                              input logic [lcdseq_pkg::HOLD_W-1:0] settle_delay);
        wait_idle();
        write_reg(lcdseq_pkg::REG_ENABLE_HOLD, enable_hold);
        write_reg(lcdseq_pkg::REG_SETTLE_DELAY, settle_delay);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Power-up run at reset timing; an unused selector must produce nothing.
    task automatic test_powerup_defaults();
        send_item(lcdseq_pkg::CMD_POWERUP, $urandom_range(0, 255), 1'b1);
        send_item(CMD_UNUSED, 8'hFF, 1'b1);
        send_item(lcdseq_pkg::CMD_POWERUP, 8'h00, 1'b0);
    endtask

    // Command bytes at the extremes; first_in_string has no effect on them.
    task automatic test_command_bytes();
        send_item(lcdseq_pkg::CMD_COMMAND, 8'h00, 1'b0);
        send_item(lcdseq_pkg::CMD_COMMAND, 8'hFF, 1'b1);
        send_item(lcdseq_pkg::CMD_COMMAND, 8'h5A, 1'b0);
    endtask

    // Wrap on the LINE_LEN-th character only, then restart a new string.
    task automatic test_line_wrap();
        send_string(LINE_LEN + 1);
        send_string(2);
    endtask

    // Zero holds, full holds and the settle sum landing right on the limit.
    task automatic test_timing_extremes();
        set_timing(16'd0, 16'd0);
        send_item(lcdseq_pkg::CMD_POWERUP, 8'hA5, 1'b0);
        send_item(lcdseq_pkg::CMD_CHAR, 8'h00, 1'b1);
        set_timing(16'hFFFF, 16'hFFFF);
        send_item(lcdseq_pkg::CMD_COMMAND, 8'hA5, 1'b0);
        send_item(lcdseq_pkg::CMD_POWERUP, 8'h3C, 1'b1);
        set_timing(16'd1, 16'd35535);
        send_item(lcdseq_pkg::CMD_POWERUP, 8'hFF, 1'b0);
    endtask

    // Mostly well-formed strings, mixed with commands, power-up runs, loose
    // characters and ignored selectors; each pass uses its own timing.
    task automatic test_random_traffic(input int n_items);
        int sent;
        int pass;
        int pass_sent;
        int kind;
        int len;
        logic [lcdseq_pkg::HOLD_W-1:0] eh;
        logic [lcdseq_pkg::HOLD_W-1:0] sd;
        sent = 0;
        pass = 0;
        while (sent < n_items) begin
            case (pass % 5)
                0: begin
                    eh = lcdseq_pkg::ENABLE_HOLD_RESET;
                    sd = lcdseq_pkg::SETTLE_DELAY_RESET;
                end
                1: begin eh = '0; sd = '0; end
                2: begin eh = 16'hFFFF; sd = 16'hFFFF; end
                default: begin
                    eh = $urandom_range(0, 65535);
                    // near the clip point of the power-up gaps half the time
                    sd = $urandom_range(0, 1) ? $urandom_range(34000, 40000)
                                              : $urandom_range(0, 65535);
                end
            endcase
            set_timing(eh, sd);
            gaps_on = (pass % 3) != 2;
            pass_sent = 0;
            while (pass_sent < ITEMS_PER_PASS && sent + pass_sent < n_items) begin
                kind = $urandom_range(0, 15);
                if (kind <= 9) begin
                    // an occasional long string runs the count into saturation
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 80)
                                                      : $urandom_range(1, 24);
                    send_string(len);
                    pass_sent += len;
                end else if (kind <= 12) begin
                    send_item(lcdseq_pkg::CMD_COMMAND, $urandom_range(0, 255),
                              $urandom_range(0, 1));
                    pass_sent++;
                end else if (kind == 13) begin
                    send_item(lcdseq_pkg::CMD_POWERUP, $urandom_range(0, 255),
                              $urandom_range(0, 1));
                    pass_sent++;
                end else if (kind == 14) begin
                    send_item(lcdseq_pkg::CMD_CHAR, $urandom_range(0, 255),
                              $urandom_range(0, 1));
                    pass_sent++;
                end else begin
                    send_item(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, 1));
                end
            end
            sent += pass_sent;
            pass++;
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        model_enable_hold  = lcdseq_pkg::ENABLE_HOLD_RESET;
        model_settle_delay = lcdseq_pkg::SETTLE_DELAY_RESET;
        model_char_count   = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_powerup_defaults();
        test_command_bytes();
        test_line_wrap();
        test_timing_extremes();
        test_random_traffic(RANDOM_ITEMS);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, then compare each phase with the oldest one
    // predicted.
    // ------------------------------------------------------------------------
    initial begin : phase_checker
        int                 stall;
        lcdseq_pkg::phase_t want;
        lcdseq_pkg::phase_t got;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.data_nibble = m_tdata[3:0];
            got.enable_line = m_tdata[4];
            got.hold_count  = m_tdata[20:5];
            got.reg_select  = m_tuser[0];
            got.last_phase  = m_tlast;
            if (pending_phases.size() == 0) begin
                $error({"unexpected phase: data_nibble %0h reg_select %0b ",
                        "enable_line %0b hold_count %0d"},
                       got.data_nibble, got.reg_select, got.enable_line, got.hold_count);
                mismatch_count++;
            end else begin
                want = pending_phases.pop_front();
                if (got.data_nibble !== want.data_nibble) begin
                    $error("data_nibble: expected %0h, got %0h", want.data_nibble,
                           got.data_nibble);
                    mismatch_count++;
                end
                if (got.reg_select !== want.reg_select) begin
                    $error("reg_select: expected %0b, got %0b", want.reg_select,
                           got.reg_select);
                    mismatch_count++;
                end
                if (got.enable_line !== want.enable_line) begin
                    $error("enable_line: expected %0b, got %0b", want.enable_line,
                           got.enable_line);
                    mismatch_count++;
                end
                if (got.hold_count !== want.hold_count) begin
                    $error("hold_count: expected %0d, got %0d", want.hold_count,
                           got.hold_count);
                    mismatch_count++;
                end
                if (got.last_phase !== want.last_phase) begin
                    $error("last_phase: expected %0b, got %0b", want.last_phase,
                           got.last_phase);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang guard: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
